// ===== sv/imps_pkg.sv =====
// Shared types and constants for the I2C master phase sequencer.
`timescale 1ns / 1ps
package imps_pkg;

    localparam int ACT_W   = 4;
    localparam int VAL_W   = 16;
    localparam int MAX_RES = 5;
    localparam int CNT_W   = 3;
    localparam int IDX_W   = 3;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [ACT_W-1:0] ACT_CTRL     = 4'd0;
    localparam logic [ACT_W-1:0] ACT_ADDR     = 4'd1;
    localparam logic [ACT_W-1:0] ACT_COUNT    = 4'd2;
    localparam logic [ACT_W-1:0] ACT_RX_MOVE  = 4'd3;
    localparam logic [ACT_W-1:0] ACT_TX_MOVE  = 4'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR    = 4'd5;
    localparam logic [ACT_W-1:0] ACT_SET_STOP = 4'd6;
    localparam logic [ACT_W-1:0] ACT_RESET    = 4'd7;
    localparam logic [ACT_W-1:0] ACT_COMPLETE = 4'd8;
    localparam logic [ACT_W-1:0] ACT_PHASE    = 4'd9;
    localparam logic [ACT_W-1:0] ACT_FAULT    = 4'd10;

    localparam logic [VAL_W-1:0] ST_AL   = 16'h0001;
    localparam logic [VAL_W-1:0] ST_NACK = 16'h0002;
    localparam logic [VAL_W-1:0] ST_ARDY = 16'h0004;
    localparam logic [VAL_W-1:0] ST_RRDY = 16'h0008;
    localparam logic [VAL_W-1:0] ST_XRDY = 16'h0010;
    localparam logic [VAL_W-1:0] ST_BB   = 16'h1000;
    localparam logic [VAL_W-1:0] ST_RDR  = 16'h2000;
    localparam logic [VAL_W-1:0] ST_XDR  = 16'h4000;

    localparam logic [VAL_W-1:0] CON_EN  = 16'h8000;
    localparam logic [VAL_W-1:0] CON_MST = 16'h0400;
    localparam logic [VAL_W-1:0] CON_TRX = 16'h0200;
    localparam logic [VAL_W-1:0] CON_STP = 16'h0002;
    localparam logic [VAL_W-1:0] CON_STT = 16'h0001;

    localparam logic [VAL_W-1:0] CODE_OK  = 16'd0;
    localparam logic [VAL_W-1:0] CODE_ERR = 16'd1;

    typedef struct packed {
        logic [CNT_W-1:0]                cnt;
        logic [MAX_RES-1:0][ACT_W-1:0]   act;
        logic [MAX_RES-1:0][VAL_W-1:0]   val;
    } plan_t;

    typedef struct packed {
        logic  valid;
        plan_t plan;
    } head_t;

endpackage

// ===== sv/i2c_master_phase_sequencer_core.sv =====
// Top level of the I2C master phase sequencer: front end, plan queue, action sequencer.
//
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   command .. control_master_stop
// out      output     out_valid / out_ready action, value, last
//
// One input transaction is taken per cycle while the two-entry plan queue has room.
// An input yields 0 to 5 actions; the sequencer sends
// one action per cycle while out_ready is high.
// Inputs that yield no action are accepted but not pushed into the plan queue.
// Reset clears transfer state, queue pointers and the action index.
// Output stalls back up into the queue; the front end stalls only when it is full.
`timescale 1ns / 1ps
module i2c_master_phase_sequencer_core
    import imps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic        phase_is_write,
    input  logic [15:0] phase_length,
    input  logic        phase_is_last,
    input  logic [9:0]  slave_address,
    input  logic [15:0] status_bits,
    input  logic [5:0]  rx_fifo_level,
    input  logic [5:0]  tx_fifo_level,
    input  logic [5:0]  rx_threshold,
    input  logic [5:0]  tx_threshold,
    input  logic [1:0]  control_master_stop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  action,
    output logic [15:0] value,
    output logic        last
);

    plan_t plan;
    head_t head;
    logic  full;
    logic  accept;
    logic  pop;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    imps_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .accept              (accept),
        .command             (command),
        .phase_is_write      (phase_is_write),
        .phase_length        (phase_length),
        .phase_is_last       (phase_is_last),
        .slave_address       (slave_address),
        .status_bits         (status_bits),
        .rx_fifo_level       (rx_fifo_level),
        .tx_fifo_level       (tx_fifo_level),
        .rx_threshold        (rx_threshold),
        .tx_threshold        (tx_threshold),
        .control_master_stop (control_master_stop),
        .plan                (plan)
    );

    imps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && (plan.cnt != '0)),
        .push_plan (plan),
        .pop       (pop),
        .full      (full),
        .head      (head)
    );

    imps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .out_ready (out_ready),
        .pop       (pop),
        .out_valid (out_valid),
        .action    (action),
        .value     (value),
        .last      (last)
    );

endmodule

// ===== sv/imps_front.sv =====
// Front end: decodes each transaction into an action plan and tracks transfer state.
`timescale 1ns / 1ps
module imps_front
    import imps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        command,
    input  logic        phase_is_write,
    input  logic [15:0] phase_length,
    input  logic        phase_is_last,
    input  logic [9:0]  slave_address,
    input  logic [15:0] status_bits,
    input  logic [5:0]  rx_fifo_level,
    input  logic [5:0]  tx_fifo_level,
    input  logic [5:0]  rx_threshold,
    input  logic [5:0]  tx_threshold,
    input  logic [1:0]  control_master_stop,
    output plan_t       plan
);

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    logic [1:0]       mode_reg, mode_next;
    logic             started_reg, started_next;
    logic             cur_last_reg, cur_last_next;
    logic [CNT_W-1:0] n;
    logic [VAL_W-1:0] con;

    always_comb
    begin
        plan          = '0;
        n             = '0;
        mode_next     = mode_reg;
        started_next  = started_reg;
        cur_last_next = cur_last_reg;
        con           = CON_EN | CON_MST | (phase_is_write ? CON_TRX : '0);
        if (!command)
        begin
            if (mode_reg == MODE_IDLE)
            begin
                plan.act[0] = ACT_CTRL;
                plan.val[0] = con;
                plan.act[1] = ACT_ADDR;
                plan.val[1] = {6'd0, slave_address};
                plan.act[2] = ACT_COUNT;
                plan.val[2] = phase_length;
                n = 3'd4;
                if (!started_reg && ((status_bits & ST_BB) != '0))
                begin
                    plan.act[3] = ACT_FAULT;
                    plan.val[3] = status_bits;
                end
                else
                begin
                    plan.act[3]   = ACT_CTRL;
                    plan.val[3]   = con | (phase_is_last ? CON_STP : '0) | CON_STT;
                    started_next  = 1'b1;
                    cur_last_next = phase_is_last;
                    mode_next     = phase_is_write ? MODE_WRITE : MODE_READ;
                end
            end
        end
        else if (mode_reg != MODE_IDLE)
        begin
            if ((status_bits & ST_NACK) != '0)
            begin
                plan.act[0]  = ACT_RESET;
                plan.val[0]  = '0;
                plan.act[1]  = ACT_COMPLETE;
                plan.val[1]  = CODE_ERR;
                n            = 3'd2;
                mode_next    = MODE_IDLE;
                started_next = 1'b0;
            end
            else
            begin
                if ((status_bits & ST_AL) != '0)
                begin
                    plan.act[n[IDX_W-1:0]] = ACT_CLEAR;
                    plan.val[n[IDX_W-1:0]] = ST_AL;
                    n = n + 3'd1;
                end
                if (((status_bits & ST_AL) != '0) && (control_master_stop == 2'd0))
                begin
                    plan.act[n[IDX_W-1:0]] = ACT_SET_STOP;
                    plan.val[n[IDX_W-1:0]] = CON_STP;
                    n = n + 3'd1;
                    plan.act[n[IDX_W-1:0]] = ACT_COMPLETE;
                    plan.val[n[IDX_W-1:0]] = CODE_ERR;
                    n = n + 3'd1;
                    mode_next    = MODE_IDLE;
                    started_next = 1'b0;
                end
                else if ((status_bits & ST_ARDY) != '0)
                begin
                    plan.act[n[IDX_W-1:0]] = ACT_CLEAR;
                    plan.val[n[IDX_W-1:0]] = ST_ARDY;
                    n = n + 3'd1;
                    mode_next = MODE_IDLE;
                    if (!cur_last_reg)
                    begin
                        plan.act[n[IDX_W-1:0]] = ACT_PHASE;
                        plan.val[n[IDX_W-1:0]] = '0;
                    end
                    else
                    begin
                        plan.act[n[IDX_W-1:0]] = ACT_COMPLETE;
                        plan.val[n[IDX_W-1:0]] = CODE_OK;
                        started_next = 1'b0;
                    end
                    n = n + 3'd1;
                end
                else
                begin
                    if ((status_bits & ST_RDR) != '0)
                    begin
                        plan.act[n[IDX_W-1:0]] = ACT_RX_MOVE;
                        plan.val[n[IDX_W-1:0]] = {10'd0, rx_fifo_level};
                        n = n + 3'd1;
                        plan.act[n[IDX_W-1:0]] = ACT_CLEAR;
                        plan.val[n[IDX_W-1:0]] = ST_RDR;
                        n = n + 3'd1;
                    end
                    else if ((status_bits & ST_RRDY) != '0)
                    begin
                        plan.act[n[IDX_W-1:0]] = ACT_RX_MOVE;
                        plan.val[n[IDX_W-1:0]] = {9'd0, {1'b0, rx_threshold} + 7'd1};
                        n = n + 3'd1;
                        plan.act[n[IDX_W-1:0]] = ACT_CLEAR;
                        plan.val[n[IDX_W-1:0]] = ST_RRDY;
                        n = n + 3'd1;
                    end
                    if ((status_bits & ST_XDR) != '0)
                    begin
                        plan.act[n[IDX_W-1:0]] = ACT_TX_MOVE;
                        plan.val[n[IDX_W-1:0]] = {10'd0, tx_fifo_level};
                        n = n + 3'd1;
                        plan.act[n[IDX_W-1:0]] = ACT_CLEAR;
                        plan.val[n[IDX_W-1:0]] = ST_XDR;
                        n = n + 3'd1;
                    end
                    else if ((status_bits & ST_XRDY) != '0)
                    begin
                        plan.act[n[IDX_W-1:0]] = ACT_TX_MOVE;
                        plan.val[n[IDX_W-1:0]] = {9'd0, {1'b0, tx_threshold} + 7'd1};
                        n = n + 3'd1;
                        plan.act[n[IDX_W-1:0]] = ACT_CLEAR;
                        plan.val[n[IDX_W-1:0]] = ST_XRDY;
                        n = n + 3'd1;
                    end
                end
            end
        end
        plan.cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            started_reg  <= 1'b0;
            cur_last_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            started_reg  <= started_next;
            cur_last_reg <= cur_last_next;
        end
    end

endmodule

// ===== sv/imps_queue.sv =====
// Short plan queue between the decode front end and the action sequencer.
`timescale 1ns / 1ps
module imps_queue
    import imps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  plan_t push_plan,
    input  logic  pop,
    output logic  full,
    output head_t head
);

    plan_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.plan  = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_plan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/imps_back.sv =====
// Back end: steps through the head plan and presents one action per transaction.
`timescale 1ns / 1ps
module imps_back
    import imps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  head_t             head,
    input  logic              out_ready,
    output logic              pop,
    output logic              out_valid,
    output logic [ACT_W-1:0]  action,
    output logic [VAL_W-1:0]  value,
    output logic              last
);

    logic [IDX_W-1:0] idx_reg, idx_next;

    assign out_valid = head.valid;
    assign action    = head.plan.act[idx_reg];
    assign value     = head.plan.val[idx_reg];
    assign last      = (idx_reg == (head.plan.cnt - 3'd1));
    assign pop       = out_valid && out_ready && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
        begin
            idx_next = '0;
        end
        else if (out_valid && out_ready)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== sv/imps_checker.sv =====
// Port-level assertions for the I2C master phase sequencer, bound to the top level.
`timescale 1ns / 1ps
module imps_checker
    import imps_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  action,
    input logic [15:0] value,
    input logic        last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(value)
            && $stable(last))
        else $error("output changed while stalled");

    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("action burst broken before last");

    a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (action <= ACT_FAULT))
        else $error("undefined action code");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((action == ACT_COMPLETE) || (action == ACT_FAULT)
            || (action == ACT_PHASE)) |-> last)
        else $error("terminal action not marked last");

    a_fault_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_FAULT) |-> value[12])
        else $error("busy fault without bus busy");

endmodule

bind i2c_master_phase_sequencer_core imps_checker u_imps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .action    (action),
    .value     (value),
    .last      (last)
);
